/* hw/rtl/lge_pkg.sv */
`default_nettype none

package lge_pkg;

	// exp(-u) constants, Q0.32 with log2(e) carrying one integer bit.
	localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	// Exponent magnitude clamp: 64.0 in Q16.16.
	localparam logic [22:0] U_LIMIT = 23'd4194304;

	localparam int unsigned SERIES_TERMS = 12;

	// floor(2^32 / k) for k = 1 .. 12, used to divide the series terms.
	localparam logic [32:0] SERIES_RECIP [SERIES_TERMS] = '{
		33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
		33'd858993459, 33'd715827882, 33'd613566756, 33'd536870912,
		33'd477218588, 33'd429496729, 33'd390451572, 33'd357913941
	};

	typedef struct packed {
		logic signed [31:0] time_point;
		logic [15:0] start_position;
		logic signed [31:0] start_time;
		logic signed [23:0] start_velocity;
	} lge_item_t;

	typedef struct packed {
		logic [16:0] position;
		logic signed [31:0] slope;
		logic saturated;
	} lge_result_t;

	// Per-item values that travel alongside the arithmetic.
	typedef struct packed {
		logic [15:0] p;
		logic [15:0] q;
		logic [31:0] pq;
		logic [23:0] av;
		logic vneg;
		logic zneg;
		logic sat;
	} lge_side_t;

endpackage

`default_nettype wire

/* hw/rtl/lge_front.sv */
`default_nettype none

module lge_front (
	input wire clk,
	input wire arst_n,
	input wire adv,
	input wire in_valid,
	input wire lge_pkg::lge_item_t item,
	output logic out_valid,
	output logic [22:0] u,
	output lge_pkg::lge_side_t side
);

	localparam int unsigned QBITS = 22;
	localparam int unsigned STAGES = 3 + QBITS;

	typedef struct packed {
		lge_pkg::lge_side_t side;
		logic [32:0] ad;
		logic [55:0] vd;
		logic [31:0] rem;
		logic [21:0] quo;
	} front_st_t;

	front_st_t st_s [1:STAGES];
	logic [STAGES:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-1:1], in_valid};
		end
	end

	// Stage 1: time difference and magnitudes.
	front_st_t nx1;
	logic [15:0] p1;
	logic signed [32:0] d1;
	always_comb begin
		nx1 = '0;
		p1 = (item.start_position == 16'd0) ? 16'd1 : item.start_position;
		d1 = 33'(item.time_point) - 33'(item.start_time);
		nx1.side.p = p1;
		nx1.side.q = 16'(17'd65536 - 17'(p1));
		nx1.side.av = item.start_velocity[23] ? 24'(-item.start_velocity)
			: 24'(item.start_velocity);
		nx1.side.vneg = item.start_velocity[23];
		nx1.side.zneg = (item.start_velocity != 24'sd0) && (d1 != 33'sd0)
			&& (item.start_velocity[23] != d1[32]);
		nx1.ad = d1[32] ? 33'(-d1) : 33'(d1);
	end

	// Stage 2: |v||d| and p(1-p).
	front_st_t nx2;
	always_comb begin
		nx2 = st_s[1];
		nx2.vd = 56'(st_s[1].side.av) * 56'(st_s[1].ad);
		nx2.side.pq = 32'(st_s[1].side.p) * 32'(st_s[1].side.q);
	end

	// Stage 3: range check and divider set-up.
	front_st_t nx3;
	always_comb begin
		nx3 = st_s[2];
		nx3.side.sat = st_s[2].vd >= 56'({st_s[2].side.pq, 6'd0});
		nx3.rem = st_s[2].vd[37:6];
		nx3.quo = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[1] <= nx1;
			st_s[2] <= nx2;
			st_s[3] <= nx3;
		end
	end

	// One quotient bit of (|v||d| << 16) / pq per stage.
	genvar j;
	for (j = 0; j < QBITS; j++) begin : g_step
		localparam int unsigned S = 4 + j;
		front_st_t nxt;
		logic [21:0] nlo;
		logic [32:0] rem2;
		always_comb begin
			nxt = st_s[S-1];
			nlo = {st_s[S-1].vd[5:0], 16'd0};
			rem2 = {st_s[S-1].rem, nlo[QBITS-1-j]};
			if (rem2 >= {1'b0, st_s[S-1].side.pq}) begin
				nxt.rem = 32'(rem2 - {1'b0, st_s[S-1].side.pq});
				nxt.quo = {st_s[S-1].quo[20:0], 1'b1};
			end else begin
				nxt.rem = rem2[31:0];
				nxt.quo = {st_s[S-1].quo[20:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[S] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign side = st_s[STAGES].side;
	assign u = st_s[STAGES].side.sat ? lge_pkg::U_LIMIT : {1'b0, st_s[STAGES].quo};

	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !side.sat |-> u < lge_pkg::U_LIMIT)
		else $error("exponent beyond clamp without saturation");

endmodule

`default_nettype wire

/* hw/rtl/lge_exp.sv */
`default_nettype none

module lge_exp (
	input wire clk,
	input wire arst_n,
	input wire adv,
	input wire in_valid,
	input wire [22:0] u,
	input wire lge_pkg::lge_side_t in_side,
	output logic out_valid,
	output logic [32:0] x,
	output lge_pkg::lge_side_t side
);

	localparam int unsigned STAGES = 3 + 3 * lge_pkg::SERIES_TERMS;

	typedef struct packed {
		lge_pkg::lge_side_t side;
		logic [7:0] n;
		logic [31:0] g;
		logic [31:0] w;
		logic [32:0] term;
		logic [32:0] r;
		logic [31:0] h;
		logic [31:0] q0;
		logic [32:0] x;
	} exp_st_t;

	exp_st_t st_s [1:STAGES];
	logic [STAGES:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-1:1], in_valid};
		end
	end

	// Stage 1: u * log2(e) splits into an integer shift n and a fraction g.
	exp_st_t nx1;
	logic [55:0] yp;
	always_comb begin
		nx1 = '0;
		nx1.side = in_side;
		yp = 56'(u) * 56'(lge_pkg::LOG2E_Q32);
		nx1.n = yp[55:48];
		nx1.g = yp[47:16];
	end

	// Stage 2: fraction back to natural units for the series.
	exp_st_t nx2;
	logic [63:0] wp;
	always_comb begin
		nx2 = st_s[1];
		wp = 64'(st_s[1].g) * 64'(lge_pkg::LN2_Q32);
		nx2.w = wp[63:32];
		nx2.term = lge_pkg::ONE_Q32;
		nx2.r = lge_pkg::ONE_Q32;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[1] <= nx1;
			st_s[2] <= nx2;
		end
	end

	// Each series term takes three stages: scale by w, multiply by 1/k,
	// then correct the quotient and accumulate with alternating sign.
	genvar i;
	for (i = 0; i < lge_pkg::SERIES_TERMS; i++) begin : g_term
		localparam int unsigned SA = 3 + 3 * i;
		localparam logic [35:0] K = 36'(i + 1);
		localparam logic SUB = ((i % 2) == 0);
		exp_st_t nxa;
		exp_st_t nxb;
		exp_st_t nxc;
		logic [64:0] hp;
		logic [64:0] mp;
		logic [35:0] rem;
		logic [31:0] tq;
		always_comb begin
			nxa = st_s[SA-1];
			hp = 65'(st_s[SA-1].term) * 65'(st_s[SA-1].w);
			nxa.h = hp[63:32];
		end
		always_comb begin
			nxb = st_s[SA];
			mp = 65'(st_s[SA].h) * 65'(lge_pkg::SERIES_RECIP[i]);
			nxb.q0 = mp[63:32];
		end
		always_comb begin
			nxc = st_s[SA+1];
			rem = 36'(st_s[SA+1].h) - 36'(st_s[SA+1].q0) * K;
			tq = st_s[SA+1].q0 + 32'(rem >= K);
			nxc.term = 33'(tq);
			if (SUB) begin
				nxc.r = st_s[SA+1].r - 33'(tq);
			end else begin
				nxc.r = st_s[SA+1].r + 33'(tq);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[SA] <= nxa;
				st_s[SA+1] <= nxb;
				st_s[SA+2] <= nxc;
			end
		end
	end

	// Final stage: apply 2^-n with rounding.
	exp_st_t nxf;
	logic [39:0] rr;
	always_comb begin
		nxf = st_s[STAGES-1];
		rr = 40'(st_s[STAGES-1].r) + (40'd1 << (st_s[STAGES-1].n - 8'd1));
		if (st_s[STAGES-1].n >= 8'd40) begin
			nxf.x = '0;
		end else if (st_s[STAGES-1].n == 8'd0) begin
			nxf.x = st_s[STAGES-1].r;
		end else begin
			nxf.x = 33'(rr >> st_s[STAGES-1].n);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[STAGES] <= nxf;
		end
	end

	assign out_valid = vld_s[STAGES];
	assign x = st_s[STAGES].x;
	assign side = st_s[STAGES].side;

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x <= lge_pkg::ONE_Q32)
		else $error("exponential above one");

endmodule

`default_nettype wire

/* hw/rtl/lge_ratio.sv */
`default_nettype none

module lge_ratio (
	input wire clk,
	input wire arst_n,
	input wire adv,
	input wire in_valid,
	input wire [32:0] x,
	input wire lge_pkg::lge_side_t in_side,
	output logic out_valid,
	output logic [32:0] s,
	output logic [32:0] c,
	output lge_pkg::lge_side_t side
);

	localparam int unsigned QBITS = 33;
	localparam int unsigned STAGES = 3 + QBITS;

	typedef struct packed {
		lge_pkg::lge_side_t side;
		logic [47:0] a;
		logic [47:0] b;
		logic [48:0] tt;
		logic [32:0] na_lo;
		logic [32:0] nb_lo;
		logic [48:0] ra;
		logic [48:0] rb;
		logic [32:0] s;
		logic [32:0] c;
	} ratio_st_t;

	ratio_st_t st_s [1:STAGES];
	logic [STAGES:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-1:1], in_valid};
		end
	end

	// Stage 1: the two weighted terms; the exponential goes on whichever
	// side keeps it below one.
	ratio_st_t nx1;
	always_comb begin
		nx1 = '0;
		nx1.side = in_side;
		if (in_side.zneg) begin
			nx1.a = 48'(in_side.p) * 48'(x);
			nx1.b = {in_side.q, 32'd0};
		end else begin
			nx1.a = {in_side.p, 32'd0};
			nx1.b = 48'(in_side.q) * 48'(x);
		end
	end

	ratio_st_t nx2;
	always_comb begin
		nx2 = st_s[1];
		nx2.tt = 49'(st_s[1].a) + 49'(st_s[1].b);
	end

	// Stage 3: add half the divisor for rounding and load both dividers.
	ratio_st_t nx3;
	logic [80:0] na;
	logic [80:0] nb;
	always_comb begin
		nx3 = st_s[2];
		na = 81'({st_s[2].a, 32'd0}) + 81'(st_s[2].tt[48:1]);
		nb = 81'({st_s[2].b, 32'd0}) + 81'(st_s[2].tt[48:1]);
		nx3.ra = 49'(na[80:33]);
		nx3.rb = 49'(nb[80:33]);
		nx3.na_lo = na[32:0];
		nx3.nb_lo = nb[32:0];
		nx3.s = '0;
		nx3.c = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[1] <= nx1;
			st_s[2] <= nx2;
			st_s[3] <= nx3;
		end
	end

	genvar j;
	for (j = 0; j < QBITS; j++) begin : g_step
		localparam int unsigned S = 4 + j;
		ratio_st_t nxt;
		logic [49:0] ra2;
		logic [49:0] rb2;
		always_comb begin
			nxt = st_s[S-1];
			ra2 = {st_s[S-1].ra, st_s[S-1].na_lo[QBITS-1-j]};
			rb2 = {st_s[S-1].rb, st_s[S-1].nb_lo[QBITS-1-j]};
			if (ra2 >= 50'(st_s[S-1].tt)) begin
				nxt.ra = 49'(ra2 - 50'(st_s[S-1].tt));
				nxt.s = {st_s[S-1].s[31:0], 1'b1};
			end else begin
				nxt.ra = ra2[48:0];
				nxt.s = {st_s[S-1].s[31:0], 1'b0};
			end
			if (rb2 >= 50'(st_s[S-1].tt)) begin
				nxt.rb = 49'(rb2 - 50'(st_s[S-1].tt));
				nxt.c = {st_s[S-1].c[31:0], 1'b1};
			end else begin
				nxt.rb = rb2[48:0];
				nxt.c = {st_s[S-1].c[31:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[S] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign s = st_s[STAGES].s;
	assign c = st_s[STAGES].c;
	assign side = st_s[STAGES].side;

endmodule

`default_nettype wire

/* hw/rtl/lge_slope.sv */
`default_nettype none

module lge_slope (
	input wire clk,
	input wire arst_n,
	input wire adv,
	input wire in_valid,
	input wire [32:0] s,
	input wire [32:0] c,
	input wire lge_pkg::lge_side_t in_side,
	output logic out_valid,
	output lge_pkg::lge_result_t res
);

	localparam int unsigned QBITS = 33;
	localparam int unsigned STAGES = 6 + QBITS;

	typedef struct packed {
		lge_pkg::lge_side_t side;
		logic [16:0] pos;
		logic [63:0] sc;
		logic [55:0] pl;
		logic [55:0] ph;
		logic [87:0] prod;
		logic [54:0] nh;
		logic big;
		logic [31:0] rem;
		logic [32:0] mag;
		lge_pkg::lge_result_t res;
	} slope_st_t;

	slope_st_t st_s [1:STAGES];
	logic [STAGES:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-1:1], in_valid};
		end
	end

	slope_st_t nx1;
	logic [65:0] scp;
	always_comb begin
		nx1 = '0;
		nx1.side = in_side;
		scp = 66'(s) * 66'(c);
		nx1.sc = scp[63:0];
		nx1.pos = 17'((34'(s) + 34'h8000) >> 16);
	end

	// The product |v| * s * c is formed from two 32-bit halves of s * c.
	slope_st_t nx2;
	always_comb begin
		nx2 = st_s[1];
		nx2.pl = 56'(st_s[1].side.av) * 56'(st_s[1].sc[31:0]);
		nx2.ph = 56'(st_s[1].side.av) * 56'(st_s[1].sc[63:32]);
	end

	slope_st_t nx3;
	always_comb begin
		nx3 = st_s[2];
		nx3.prod = 88'({st_s[2].ph, 32'd0}) + 88'(st_s[2].pl);
	end

	// Dividing by pq * 2^32 is the same as dropping 32 bits and dividing by pq.
	slope_st_t nx4;
	logic [87:0] nsum;
	always_comb begin
		nx4 = st_s[3];
		nsum = st_s[3].prod + 88'({st_s[3].side.pq, 31'd0});
		nx4.nh = nsum[86:32];
	end

	// A quotient of 2^33 or more saturates whatever its exact value.
	slope_st_t nx5;
	always_comb begin
		nx5 = st_s[4];
		nx5.big = 32'(st_s[4].nh[54:33]) >= st_s[4].side.pq;
		nx5.rem = 32'(st_s[4].nh[54:33]);
		nx5.mag = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[1] <= nx1;
			st_s[2] <= nx2;
			st_s[3] <= nx3;
			st_s[4] <= nx4;
			st_s[5] <= nx5;
		end
	end

	genvar j;
	for (j = 0; j < QBITS; j++) begin : g_step
		localparam int unsigned S = 6 + j;
		slope_st_t nxt;
		logic [32:0] rem2;
		always_comb begin
			nxt = st_s[S-1];
			rem2 = {st_s[S-1].rem, st_s[S-1].nh[QBITS-1-j]};
			if (rem2 >= {1'b0, st_s[S-1].side.pq}) begin
				nxt.rem = 32'(rem2 - {1'b0, st_s[S-1].side.pq});
				nxt.mag = {st_s[S-1].mag[31:0], 1'b1};
			end else begin
				nxt.rem = rem2[31:0];
				nxt.mag = {st_s[S-1].mag[31:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[S] <= nxt;
			end
		end
	end

	slope_st_t nxf;
	logic clamp;
	always_comb begin
		nxf = st_s[STAGES-1];
		if (!st_s[STAGES-1].side.vneg) begin
			clamp = st_s[STAGES-1].big || (st_s[STAGES-1].mag > 33'h0_7FFF_FFFF);
			nxf.res.slope = clamp ? 32'sh7FFF_FFFF : st_s[STAGES-1].mag[31:0];
		end else begin
			clamp = st_s[STAGES-1].big || (st_s[STAGES-1].mag > 33'h0_8000_0000);
			nxf.res.slope = clamp ? 32'sh8000_0000 : 32'(33'd0 - st_s[STAGES-1].mag);
		end
		nxf.res.position = st_s[STAGES-1].pos;
		nxf.res.saturated = st_s[STAGES-1].side.sat || clamp;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[STAGES] <= nxf;
		end
	end

	assign out_valid = vld_s[STAGES];
	assign res = st_s[STAGES].res;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res.position <= 17'd65536)
		else $error("position above one");

	a_slope_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !st_s[STAGES].side.vneg |-> !res.slope[31])
		else $error("slope sign differs from velocity sign");

endmodule

`default_nettype wire

/* hw/rtl/logistic_geodesic_eval_top.sv */
// Logistic curve evaluator: position and time derivative of a logistic
// curve through (t0, p0) with velocity v0, sampled at time t.
// Input channel item / item_valid / item_stall carries t, p0, t0 and v0;
// a request is taken at a rising edge with item_valid high and item_stall low.
// Output channel result / result_valid / result_stall returns position,
// slope and the saturation flag, one result per request, in request order.
// In order from acceptance to result_valid, 25 stages form the exponent
// with a bit-serial divider, 39 evaluate the exponential series, 36 run the
// two rounding dividers for the position ratios, 39 form and divide the
// slope, and one output stage. Throughput is one request per cycle while
// the output buffer has room; every stage advances together. The output
// holds two results. When result_stall keeps it full, the whole pipeline
// freezes and item_stall rises from the next cycle; nothing in flight is
// lost or repeated. Reset clears all valid bits and the output buffer; the
// block accepts a request in the first cycle after reset.
`default_nettype none

module logistic_geodesic_eval_top (
	input wire clk,
	input wire arst_n,
	input wire item_valid,
	output logic item_stall,
	input wire lge_pkg::lge_item_t item,
	output logic result_valid,
	input wire result_stall,
	output lge_pkg::lge_result_t result
);

	logic adv;
	logic front_valid;
	logic [22:0] front_u;
	lge_pkg::lge_side_t front_side;
	logic exp_valid;
	logic [32:0] exp_x;
	lge_pkg::lge_side_t exp_side;
	logic ratio_valid;
	logic [32:0] ratio_s;
	logic [32:0] ratio_c;
	lge_pkg::lge_side_t ratio_side;
	logic slope_valid;
	lge_pkg::lge_result_t slope_res;

	lge_pkg::lge_result_t buf_q [2];
	logic [1:0] count_q;
	logic wr_q;
	logic rd_q;
	logic push;
	logic pop;

	lge_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(item_valid),
		.item(item),
		.out_valid(front_valid),
		.u(front_u),
		.side(front_side)
	);

	lge_exp u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(front_valid),
		.u(front_u),
		.in_side(front_side),
		.out_valid(exp_valid),
		.x(exp_x),
		.side(exp_side)
	);

	lge_ratio u_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(exp_valid),
		.x(exp_x),
		.in_side(exp_side),
		.out_valid(ratio_valid),
		.s(ratio_s),
		.c(ratio_c),
		.side(ratio_side)
	);

	lge_slope u_slope (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(ratio_valid),
		.s(ratio_s),
		.c(ratio_c),
		.in_side(ratio_side),
		.out_valid(slope_valid),
		.res(slope_res)
	);

	// The pipeline moves whenever the output buffer has a free entry, so
	// the stall seen at the input comes from a register only.
	assign adv = (count_q != 2'd2);
	assign item_stall = !adv;
	assign push = adv && slope_valid;
	assign result_valid = (count_q != 2'd0);
	assign pop = result_valid && !result_stall;
	assign result = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= slope_res;
		end
	end

	a_buf_drain: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |=> count_q != 2'd0)
		else $error("output buffer emptied by more than one result in a cycle");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |=> count_q == 2'd2 || count_q == 2'd1)
		else $error("output buffer occupancy out of range");

endmodule

`default_nettype wire
